FILE: sv/irbt_pkg.sv
// Shared types, constants and helper functions of the IR blob pointer tracker.
`timescale 1ns / 1ps
`default_nettype none

package irbt_pkg;

  // Blob slots carried on the input stream and the number actually used.
  localparam int MAX_BLOBS = 4;
  localparam int NUM_BLOBS = 4;
  localparam int RAW_W     = 24;

  // Coordinate, spread and normalised widths.
  localparam int COORD_W  = 10;
  localparam int SPREAD_W = 11;
  localparam int HDY_W    = 11;
  localparam int MISS_W   = 4;
  localparam int NORM_W   = 10;

  // Geometry constants.
  localparam logic [COORD_W-1:0] EMPTY_COORD = 10'd1023;
  localparam logic [COORD_W-1:0] SPAN_X      = 10'd1023;
  localparam logic [COORD_W-1:0] SPAN_Y      = 10'd767;
  localparam logic [NORM_W-1:0]  NORM_FULL   = 10'd1000;
  localparam logic [NORM_W-1:0]  NORM_MID    = 10'd500;
  localparam logic [MISS_W-1:0]  LIMIT_RESET = 4'd3;

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_STEPS = NORM_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);
  localparam int PROD_W    = 2 * NORM_W;

  // Stream widths.
  localparam int IN_DATA_W  = MAX_BLOBS * RAW_W;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // Remembered tracker state.
  typedef struct packed {
    logic [COORD_W-1:0] half_dx;
    logic [HDY_W-1:0]   half_dy;
    logic [COORD_W-1:0] last_cx;
    logic [COORD_W-1:0] last_cy;
    logic [MISS_W-1:0]  missed_frames;
    logic               spread_known;
  } trk_state_t;

  // Outcome of the centre stage for one frame.
  typedef struct packed {
    logic [MAX_BLOBS-1:0] mask;
    logic                 valid;
    logic                 est;
    logic                 two_blob;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [SPREAD_W-1:0]  extent_x;
    logic [SPREAD_W-1:0]  extent_y;
    logic [COORD_W-1:0]   new_half_dx;
    logic [HDY_W-1:0]     new_half_dy;
  } centre_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // X coordinate of a packed blob record.
  function automatic logic [COORD_W-1:0] blob_x(input logic [RAW_W-1:0] r);
    blob_x = {r[21:20], r[7:0]};
  endfunction

  // Y coordinate of a packed blob record.
  function automatic logic [COORD_W-1:0] blob_y(input logic [RAW_W-1:0] r);
    blob_y = {r[23:22], r[15:8]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/irbt_center.sv
// Blob decoding, pair selection and centre estimation for one frame.
`timescale 1ns / 1ps
`default_nettype none

module irbt_center
  import irbt_pkg::*;
(
  input  wire logic [IN_DATA_W-1:0] blobs,
  input  wire trk_state_t           trk,
  input  wire logic [MISS_W-1:0]    dropout_limit,
  output centre_t                   res
);

  logic [COORD_W-1:0]     x;
  logic [COORD_W-1:0]     y;
  logic                   vld;
  logic [1:0]             cnt;
  logic [COORD_W-1:0]     xa, ya, xb, yb;
  logic [COORD_W-1:0]     xl, yl, xr, yr;
  logic [COORD_W:0]       sum_x, sum_y;
  logic signed [HDY_W-1:0] dy;
  logic signed [HDY_W-1:0] hdy2;
  logic [COORD_W-1:0]     abs_dy;
  logic signed [12:0]     ex, ey;
  logic signed [HDY_W-1:0] hdy_m;
  logic [COORD_W-1:0]     abs_hdy;
  logic                   est_ok;

  always_comb begin
    // Decode the slots and pick the first two occupied ones.
    res   = '0;
    cnt   = 2'd0;
    xa    = '0;
    ya    = '0;
    xb    = '0;
    yb    = '0;
    x     = '0;
    y     = '0;
    vld   = 1'b0;
    for (int i = 0; i < MAX_BLOBS; i++) begin
      x   = blob_x(blobs[i*RAW_W +: RAW_W]);
      y   = blob_y(blobs[i*RAW_W +: RAW_W]);
      vld = (i < NUM_BLOBS) && !((x == EMPTY_COORD) && (y == EMPTY_COORD));
      res.mask[i] = vld;
      if (vld) begin
        if (cnt == 2'd0) begin
          xa = x;
          ya = y;
        end else if (cnt == 2'd1) begin
          xb = x;
          yb = y;
        end
        if (cnt != 2'd2) begin
          cnt = cnt + 2'd1;
        end
      end
    end

    // Order the pair by x.
    if (xa > xb) begin
      xl = xb;
      yl = yb;
      xr = xa;
      yr = ya;
    end else begin
      xl = xa;
      yl = ya;
      xr = xb;
      yr = yb;
    end

    // Midpoint and half spread of the pair; the y half spread rounds toward zero.
    sum_x  = {1'b0, xl} + {1'b0, xr};
    sum_y  = {1'b0, yl} + {1'b0, yr};
    dy     = $signed({1'b0, yr}) - $signed({1'b0, yl});
    hdy2   = (dy + $signed({{(HDY_W-1){1'b0}}, dy[HDY_W-1]})) >>> 1;
    abs_dy = dy[HDY_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];

    // Single-blob estimate from the remembered spread, clamped to the sensor.
    hdy_m = $signed(trk.half_dy);
    if (xa <= trk.last_cx) begin
      ex = $signed({3'b0, xa}) + $signed({3'b0, trk.half_dx});
      ey = $signed({3'b0, ya}) + $signed({{2{hdy_m[HDY_W-1]}}, hdy_m});
    end else begin
      ex = $signed({3'b0, xa}) - $signed({3'b0, trk.half_dx});
      ey = $signed({3'b0, ya}) - $signed({{2{hdy_m[HDY_W-1]}}, hdy_m});
    end
    if (ex < 0) begin
      ex = '0;
    end else if (ex > $signed({3'b0, SPAN_X})) begin
      ex = $signed({3'b0, SPAN_X});
    end
    if (ey < 0) begin
      ey = '0;
    end else if (ey > $signed({3'b0, SPAN_Y})) begin
      ey = $signed({3'b0, SPAN_Y});
    end
    abs_hdy = hdy_m[HDY_W-1] ? COORD_W'(-hdy_m) : hdy_m[COORD_W-1:0];

    est_ok = (cnt == 2'd1) && trk.spread_known && (trk.missed_frames < dropout_limit);

    if (cnt == 2'd2) begin
      res.valid       = 1'b1;
      res.two_blob    = 1'b1;
      res.cx          = sum_x[COORD_W:1];
      res.cy          = sum_y[COORD_W:1];
      res.extent_x    = {1'b0, xr - xl};
      res.extent_y    = {1'b0, abs_dy};
      res.new_half_dx = {1'b0, xr[COORD_W-1:1] - xl[COORD_W-1:1]
                         - {{(COORD_W-2){1'b0}}, (~xr[0] & xl[0])}};
      res.new_half_dy = hdy2;
    end else if (est_ok) begin
      res.valid    = 1'b1;
      res.est      = 1'b1;
      res.cx       = ex[COORD_W-1:0];
      res.cy       = ey[COORD_W-1:0];
      res.extent_x = {trk.half_dx, 1'b0};
      res.extent_y = {abs_hdy, 1'b0};
    end
  end

endmodule

`default_nettype wire

FILE: sv/irbt_norm_div.sv
// Shared normalising unit: offset times 1000 over the usable span, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module irbt_norm_div
  import irbt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [COORD_W-1:0]  centre,
  input  wire logic [SPREAD_W-1:0] spread,
  input  wire logic [COORD_W-1:0]  span,
  output div_stat_t                stat,
  output logic [NORM_W-1:0]        result
);

  logic signed [12:0]  usable;
  logic signed [12:0]  diff;
  logic [PROD_W-1:0]   prod;
  logic [COORD_W-1:0]  divisor;
  logic [COORD_W-1:0]  rem;
  logic [NORM_W-1:0]   quo;
  logic [DIVCNT_W-1:0] cnt;
  logic [COORD_W:0]    trial;
  logic                qbit;
  logic [COORD_W-1:0]  rem_next;
  logic [NORM_W-1:0]   quo_next;

  // Operand set-up: usable span, offset from the spread edge, and the scaled dividend.
  always_comb begin
    usable = $signed({3'b0, span}) - $signed({2'b0, spread});
    diff   = $signed({3'b0, centre}) - $signed({3'b0, spread[SPREAD_W-1:1]});
    prod   = PROD_W'(diff[NORM_W-1:0]) * PROD_W'(NORM_FULL);
  end

  // One restoring step of the division.
  always_comb begin
    trial    = {rem, quo[NORM_W-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? COORD_W'(trial - {1'b0, divisor}) : trial[COORD_W-1:0];
    quo_next = {quo[NORM_W-2:0], qbit};
  end

  // Control of the serial divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        if (usable <= 0 || diff <= 0 || diff >= usable) begin
          stat.done <= 1'b1;
          stat.busy <= 1'b0;
        end else begin
          stat.busy <= 1'b1;
          cnt       <= '0;
        end
      end else if (stat.busy) begin
        cnt <= cnt + DIVCNT_W'(1);
        if (cnt == DIVCNT_W'(DIV_STEPS - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Dividend, divisor and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= usable[COORD_W-1:0];
      rem     <= prod[PROD_W-1:NORM_W];
      quo     <= prod[NORM_W-1:0];
      if (usable <= 0) begin
        result <= NORM_MID;
      end else if (diff <= 0) begin
        result <= '0;
      end else begin
        result <= NORM_FULL;
      end
    end else if (stat.busy) begin
      rem <= rem_next;
      quo <= quo_next;
      if (cnt == DIVCNT_W'(DIV_STEPS - 1)) begin
        result <= quo_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ir_blob_pointer_tracker_top.sv
// Top level of the IR blob pointer tracker: sequencer, tracker state and output register.
//
// Use: each transfer on the s_ channel carries one camera frame of four packed
// blob records. The block finds the pointer centre, updates its remembered
// spread and answers with exactly one result transfer on the m_ channel.
// The cfg channel writes the dropout limit; it is always ready and should only
// be written while no frame is in progress.
// Sequence: a frame with a centre goes to the x axis, then to the y axis, each
// a start step and a run step on the one shared serial divider, one quotient
// bit per cycle; an axis whose span is empty or whose offset clamps is settled
// at once without the full division. A frame with no centre goes straight to
// the last step. That divider sets the rate: one frame at a time, s_tready
// high only while the sequencer waits for a frame.
// The result sits in an output register; the next frame is taken while it
// waits. If the receiver stalls, a finished frame waits in its last step
// until the output register is free.
// Reset clears the remembered spread, the missed-frame count and the output
// valid, and sets the dropout limit to 3.
`timescale 1ns / 1ps
`default_nettype none

module ir_blob_pointer_tracker_top
  import irbt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Frame input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata: blob0_raw[23:0], blob1_raw[47:24], blob2_raw[71:48], blob3_raw[95:72]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // Result output
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata: blob_valid_mask[3:0], center_x_out[13:4], center_y_out[23:14],
  //          norm_x_out[33:24], norm_y_out[43:34], zero[47:44]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: center_valid[0], center_estimated[1]
  output logic [OUT_USER_W-1:0]      m_tuser,
  // Dropout limit write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [MISS_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_XSTART = 3'd1;
  localparam logic [2:0] ST_XRUN   = 3'd2;
  localparam logic [2:0] ST_YSTART = 3'd3;
  localparam logic [2:0] ST_YRUN   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [MISS_W-1:0]    dropout_limit;
  trk_state_t           trk;
  centre_t              cres;
  centre_t              frame;
  logic [NORM_W-1:0]    norm_x;
  logic                 div_start;
  logic                 div_axis_y;
  logic [COORD_W-1:0]   div_centre;
  logic [SPREAD_W-1:0]  div_spread;
  logic [COORD_W-1:0]   div_span;
  div_stat_t            div_stat;
  logic [NORM_W-1:0]    div_result;
  logic                 in_xfer;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Dropout limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dropout_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dropout_limit <= cfg_data;
    end
  end

  irbt_center u_center (
    .blobs         (s_tdata),
    .trk           (trk),
    .dropout_limit (dropout_limit),
    .res           (cres)
  );

  // Tracker state is updated as the frame is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      trk <= '0;
    end else if (in_xfer) begin
      if (cres.two_blob) begin
        trk.half_dx       <= cres.new_half_dx;
        trk.half_dy       <= cres.new_half_dy;
        trk.last_cx       <= cres.cx;
        trk.last_cy       <= cres.cy;
        trk.missed_frames <= '0;
        trk.spread_known  <= 1'b1;
      end else if (cres.est) begin
        trk.missed_frames <= trk.missed_frames + MISS_W'(1);
      end
    end
  end

  // Frame working register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame <= cres;
    end
    if (div_stat.done && !div_axis_y) begin
      norm_x <= div_result;
    end
  end

  // Operands of the shared divider for the current axis.
  always_comb begin
    div_axis_y = (state == ST_YSTART) || (state == ST_YRUN);
    div_start  = (state == ST_XSTART) || (state == ST_YSTART);
    div_centre = div_axis_y ? frame.cy : frame.cx;
    div_spread = div_axis_y ? frame.extent_y : frame.extent_x;
    div_span   = div_axis_y ? SPAN_Y : SPAN_X;
  end

  irbt_norm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .centre (div_centre),
    .spread (div_spread),
    .span   (div_span),
    .stat   (div_stat),
    .result (div_result)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_xfer) state_next = cres.valid ? ST_XSTART : ST_FINISH;
      ST_XSTART: state_next = ST_XRUN;
      ST_XRUN:   if (div_stat.done) state_next = ST_YSTART;
      ST_YSTART: state_next = ST_YRUN;
      ST_YRUN:   if (div_stat.done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register; a frame with no centre reports zeros beyond the blob mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tuser <= {frame.est, frame.valid};
      if (frame.valid) begin
        m_tdata <= {4'b0, div_result, norm_x, frame.cy, frame.cx, frame.mask};
      end else begin
        m_tdata <= {{(OUT_DATA_W-MAX_BLOBS){1'b0}}, frame.mask};
      end
    end
  end

  // An estimated centre is always a valid centre.
  a_est_implies_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("estimated flag without a valid centre");

  // Without a centre all coordinate fields are zero.
  a_no_centre_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[OUT_DATA_W-1:MAX_BLOBS] == '0)
    else $error("coordinates present without a centre");

  // Normalised positions stay within 0..1000.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:24] <= NORM_FULL) && (m_tdata[43:34] <= NORM_FULL))
    else $error("normalised position out of range");

  // Missed frames only count up once a spread is remembered.
  a_missed_needs_spread: assert property (@(posedge clk) disable iff (rst)
    !trk.spread_known |-> trk.missed_frames == '0)
    else $error("missed frames counted with no spread");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench of the IR blob pointer tracker: framed stimulus, predictor and checks.
`timescale 1ns / 1ps

module tb_top;
  import irbt_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 150;
  localparam int SETTLE_CYCLES = 40;

  // One pointer result as it appears on the output stream.
  typedef struct packed {
    logic [MAX_BLOBS-1:0] mask;
    logic                 valid;
    logic                 est;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [NORM_W-1:0]    nx;
    logic [NORM_W-1:0]    ny;
  } pointer_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MISS_W-1:0]     cfg_data = '0;

  // Frames waiting to be sent and pointer results still owed by the block.
  logic [IN_DATA_W-1:0] pending_frames[$];
  pointer_result_t      predicted_pointers[$];

  // Tracker state as the testbench believes it to be.
  logic [COORD_W-1:0]      trk_half_dx = '0;
  logic signed [HDY_W-1:0] trk_half_dy = '0;
  logic [COORD_W-1:0]      trk_last_cx = '0;
  logic [COORD_W-1:0]      trk_last_cy = '0;
  logic [MISS_W-1:0]       trk_missed = '0;
  logic                    trk_spread_known = 1'b0;
  logic [MISS_W-1:0]       trk_limit = LIMIT_RESET;

  int gap_odds = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;
  int n_errors = 0;
  int n_frames = 0;
  int n_results = 0;
  int n_pairs = 0;
  int n_estimates = 0;
  int n_blank = 0;
  int n_cfg_writes = 0;

  ir_blob_pointer_tracker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Normalised position along one axis, truncated toward zero and clamped to 0..1000; 500 for an empty span.
  function automatic logic [NORM_W-1:0] scale_axis(input int c, input int spread, input int span);
    int usable;
    int q;
    usable = span - spread;
    if (usable <= 0) return NORM_MID;
    q = (c - spread / 2) * int'(NORM_FULL) / usable;
    if (q < 0) q = 0;
    if (q > int'(NORM_FULL)) q = int'(NORM_FULL);
    return NORM_W'(q);
  endfunction

  // Works out the pointer result of one frame and moves the tracker state on.
  function automatic pointer_result_t track_frame(input logic [IN_DATA_W-1:0] f);
    pointer_result_t r;
    int vx[MAX_BLOBS];
    int vy[MAX_BLOBS];
    int n, xl, yl, xr, yr, t, hdx, hdy, cx, cy;
    logic [RAW_W-1:0] rec;
    logic [COORD_W-1:0] x, y;
    r = '0;
    n = 0;
    for (int i = 0; i < NUM_BLOBS; i++) begin
      rec = f[i*RAW_W +: RAW_W];
      x = {rec[21:20], rec[7:0]};
      y = {rec[23:22], rec[15:8]};
      if (!(x == EMPTY_COORD && y == EMPTY_COORD)) begin
        r.mask[i] = 1'b1;
        vx[n] = int'(x);
        vy[n] = int'(y);
        n++;
      end
    end
    if (n >= 2) begin
      // Two blobs: the midpoint of the first two, left one first.
      xl = vx[0]; yl = vy[0]; xr = vx[1]; yr = vy[1];
      if (xl > xr) begin
        t = xl; xl = xr; xr = t;
        t = yl; yl = yr; yr = t;
      end
      cx = (xl + xr) / 2;
      cy = (yl + yr) / 2;
      hdy = (yr - yl) / 2;
      trk_half_dx = COORD_W'((xr - xl) / 2);
      trk_half_dy = HDY_W'(hdy);
      trk_last_cx = COORD_W'(cx);
      trk_last_cy = COORD_W'(cy);
      trk_missed = '0;
      trk_spread_known = 1'b1;
      r.valid = 1'b1;
      r.cx = COORD_W'(cx);
      r.cy = COORD_W'(cy);
      r.nx = scale_axis(cx, xr - xl, int'(SPAN_X));
      r.ny = scale_axis(cy, (yr >= yl) ? yr - yl : yl - yr, int'(SPAN_Y));
    end else if (n == 1 && trk_spread_known && trk_missed < trk_limit) begin
      // One blob: guess the other from the remembered half spread.
      hdx = int'(trk_half_dx);
      hdy = trk_half_dy;
      if (vx[0] <= int'(trk_last_cx)) begin
        cx = vx[0] + hdx;
        cy = vy[0] + hdy;
      end else begin
        cx = vx[0] - hdx;
        cy = vy[0] - hdy;
      end
      if (cx < 0) cx = 0;
      if (cx > int'(SPAN_X)) cx = int'(SPAN_X);
      if (cy < 0) cy = 0;
      if (cy > int'(SPAN_Y)) cy = int'(SPAN_Y);
      trk_missed = trk_missed + 1'b1;
      r.valid = 1'b1;
      r.est = 1'b1;
      r.cx = COORD_W'(cx);
      r.cy = COORD_W'(cy);
      r.nx = scale_axis(cx, 2 * hdx, int'(SPAN_X));
      r.ny = scale_axis(cy, 2 * ((hdy >= 0) ? hdy : -hdy), int'(SPAN_Y));
    end
    return r;
  endfunction

  // Packs one blob record.
  function automatic logic [RAW_W-1:0] blob_rec(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [3:0] size);
    return {y[9:8], x[9:8], size, y[7:0], x[7:0]};
  endfunction

  // A real blob near the given point, kept off the empty marker, with a random size.
  function automatic logic [RAW_W-1:0] blob_at(input int x, input int y);
    if (x < 0) x = 0;
    if (x > int'(EMPTY_COORD)) x = int'(EMPTY_COORD);
    if (y < 0) y = 0;
    if (y > int'(EMPTY_COORD)) y = int'(EMPTY_COORD);
    if (x == int'(EMPTY_COORD) && y == int'(EMPTY_COORD)) y = $urandom_range(0, 1022);
    return blob_rec(COORD_W'(x), COORD_W'(y), 4'($urandom));
  endfunction

  function automatic logic [RAW_W-1:0] empty_rec();
    return blob_rec(EMPTY_COORD, EMPTY_COORD, 4'($urandom));
  endfunction

  // A frame with a single blob in the given slot.
  function automatic logic [IN_DATA_W-1:0] lone_frame(input int slot, input logic [RAW_W-1:0] b);
    logic [IN_DATA_W-1:0] f;
    for (int i = 0; i < MAX_BLOBS; i++) f[i*RAW_W +: RAW_W] = (i == slot) ? b : empty_rec();
    return f;
  endfunction

  task automatic push4(input logic [RAW_W-1:0] b0, input logic [RAW_W-1:0] b1,
                       input logic [RAW_W-1:0] b2, input logic [RAW_W-1:0] b3);
    pending_frames.push_back({b3, b2, b1, b0});
  endtask

  // Hand-picked frames: empty frames, swapped pairs, estimate runs up to the limit,
  // empty spans, clamps and coordinates at the ends of their range.
  task automatic directed_frames();
    logic [RAW_W-1:0] e;
    e = blob_rec(EMPTY_COORD, EMPTY_COORD, 4'd0);
    push4(e, e, e, blob_rec(EMPTY_COORD, EMPTY_COORD, 4'hf));
    push4(e, e, e, blob_rec(10'd0, 10'd0, 4'hf));
    push4(blob_rec(10'd900, 10'd100, 4'd3), blob_rec(10'd100, 10'd700, 4'd5), e, e);
    push4(e, blob_rec(10'd200, 10'd650, 4'd0), e, e);
    push4(e, e, blob_rec(10'd800, 10'd100, 4'd1), e);
    push4(e, e, e, blob_rec(10'd1023, 10'd0, 4'd0));
    push4(blob_rec(10'd10, 10'd10, 4'd0), e, e, e);
    push4(blob_rec(10'd0, 10'd0, 4'd0), blob_rec(10'd1023, 10'd767, 4'd0), e, e);
    push4(blob_rec(10'd0, 10'd1023, 4'd0), blob_rec(10'd2, 10'd1023, 4'd0), e, e);
    push4(blob_rec(10'd500, 10'd300, 4'd0), blob_rec(10'd500, 10'd400, 4'd0), e, e);
    push4(blob_rec(10'd1023, 10'd1022, 4'd9), blob_rec(10'd0, 10'd5, 4'd6),
          blob_rec(10'd600, 10'd600, 4'd2), blob_rec(10'd700, 10'd10, 4'd4));
    push4(e, blob_rec(10'd300, 10'd200, 4'd0), blob_rec(10'd310, 10'd900, 4'd0),
          blob_rec(10'd20, 10'd20, 4'd0));
    push4(blob_rec(10'd0, 10'd0, 4'd0), blob_rec(10'd1000, 10'd700, 4'd0), e, e);
    push4(blob_rec(10'd500, 10'd700, 4'd0), e, e, e);
    push4(e, blob_rec(10'd1023, 10'd0, 4'd0), e, e);
    push4(e, e, blob_rec(10'd0, 10'd1023, 4'd0), e);
    push4(e, e, e, blob_rec(10'd1, 10'd1, 4'd0));
    push4(blob_rec(10'd1023, 10'd0, 4'd0), blob_rec(10'd1020, 10'd1023, 4'd0), e, e);
    push4(e, blob_rec(10'd1021, 10'd5, 4'd0), e, e);
    push4(e, e, blob_rec(10'd1022, 10'd5, 4'd0), e);
    push4(e, e, e, e);
    push4(blob_rec(10'd1023, 10'd1022, 4'd0), e, e, e);
    push4(e, e, e, blob_rec(10'd512, 10'd512, 4'd0));
  endtask

  // Random frames, mostly two or more blobs followed by a run of lone-blob frames
  // near the first two, with empty frames, stray lone blobs and fully random frames mixed in.
  task automatic gen_frames(input int n);
    int made, kind, run, k, picked, bx, by;
    logic [MAX_BLOBS-1:0] sel;
    logic [IN_DATA_W-1:0] f;
    int anc_x[2];
    int anc_y[2];
    made = 0;
    anc_x[0] = 0; anc_y[0] = 0; anc_x[1] = 0; anc_y[1] = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        do sel = MAX_BLOBS'($urandom); while ((sel & (sel - 1'b1)) == '0);
        picked = 0;
        for (int i = 0; i < MAX_BLOBS; i++) begin
          if (sel[i]) begin
            bx = $urandom_range(0, 1023);
            by = $urandom_range(0, 1023);
            if (picked < 2) begin
              anc_x[picked] = bx;
              anc_y[picked] = by;
            end
            picked++;
            f[i*RAW_W +: RAW_W] = blob_at(bx, by);
          end else begin
            f[i*RAW_W +: RAW_W] = empty_rec();
          end
        end
        pending_frames.push_back(f);
        made++;
        run = $urandom_range(0, 17);
        repeat (run) begin
          k = $urandom_range(0, 1);
          if ($urandom_range(0, 7) == 0) begin
            f = lone_frame(MAX_BLOBS, '0);
          end else if ($urandom_range(0, 2) != 0) begin
            bx = anc_x[k] + int'($urandom_range(0, 32)) - 16;
            by = anc_y[k] + int'($urandom_range(0, 32)) - 16;
            f = lone_frame($urandom_range(0, 3), blob_at(bx, by));
          end else begin
            f = lone_frame($urandom_range(0, 3),
                           blob_at($urandom_range(0, 1023), $urandom_range(0, 1023)));
          end
          pending_frames.push_back(f);
          made++;
        end
      end else if (kind == 7) begin
        pending_frames.push_back(lone_frame(MAX_BLOBS, '0));
        made++;
      end else if (kind == 8) begin
        pending_frames.push_back({$urandom, $urandom, $urandom});
        made++;
      end else begin
        pending_frames.push_back(lone_frame($urandom_range(0, 3),
                                 blob_at($urandom_range(0, 1023), $urandom_range(0, 1023))));
        made++;
      end
    end
  endtask

  // Writes the dropout limit through the configuration channel.
  task automatic write_limit(input logic [MISS_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trk_limit = v;
    n_cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued frame has gone and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (pending_frames.size() != 0 || s_tvalid || predicted_pointers.size() != 0);
  endtask

  task automatic run_phase(input logic [MISS_W-1:0] lim, input int odds, input int n);
    gap_odds = odds;
    write_limit(lim);
    @(negedge clk);
    gen_frames(n);
    drain();
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Frame sender: offers the oldest pending frame, with random gaps between transfers.
  always @(posedge clk) begin : frame_sender
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_pointers.push_back(track_frame(s_tdata));
        void'(pending_frames.pop_front());
        n_frames++;
      end
      if (s_tvalid && !s_tready) begin
        // The offered frame stays on the bus until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_frames.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        send_gap = $urandom_range(0, 10);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_frames[0];
      end
    end
  end

  // Result receiver: checks each transfer against the oldest prediction and
  // throttles m_tready, once with a long hold-off to back the block up.
  always @(posedge clk) begin : result_receiver
    pointer_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (predicted_pointers.size() == 0) begin
          $display("%0t ns: result with no frame outstanding, expected none, actual %h/%b",
                   $time, m_tdata, m_tuser);
          n_errors++;
        end else begin
          want = predicted_pointers.pop_front();
          check_field("blob_valid_mask", want.mask, m_tdata[3:0]);
          check_field("center_valid", want.valid, m_tuser[0]);
          check_field("center_estimated", want.est, m_tuser[1]);
          check_field("center_x_out", want.cx, m_tdata[13:4]);
          check_field("center_y_out", want.cy, m_tdata[23:14]);
          check_field("norm_x_out", want.nx, m_tdata[33:24]);
          check_field("norm_y_out", want.ny, m_tdata[43:34]);
          check_field("tdata padding", 0, m_tdata[47:44]);
          if (want.est) n_estimates++;
          else if (want.valid) n_pairs++;
          else n_blank++;
        end
      end
      if (!hold_done && n_results == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        recv_gap = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence: reset, directed frames at the reset limit, then random phases
  // through a spread of dropout limits, the last one without idling.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    gap_odds = 4;
    directed_frames();
    drain();
    run_phase(4'd0, 3, 80);
    run_phase(4'd15, 5, 130);
    run_phase(4'd1, 2, 80);
    run_phase(MISS_W'($urandom_range(2, 14)), 8, 90);
    run_phase(MISS_W'($urandom_range(0, 15)), 0, 100);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d frames over %0d limit writes: %0d pair centres, %0d estimates, %0d blank.",
             n_frames, n_cfg_writes, n_pairs, n_estimates, n_blank);
    $display("Checked %0d results with one %0d-cycle receiver hold-off; %0d mismatches.",
             n_results, HOLD_CYCLES, n_errors);
    if (n_errors == 0 && predicted_pointers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
